// ----- hw/rtl/rlfw_pkg.sv -----
// types and constants shared by the recursive lock blocks
`timescale 1ns / 1ps
`default_nettype none

package rlfw_pkg;

    localparam int ID_W    = 8;
    localparam int DEPTH_W = 8;

    localparam logic FUNC_ACQUIRE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    typedef enum logic [3:0] {
        ST_GRANTED    = 4'd0,
        ST_REGRANTED  = 4'd1,
        ST_QUEUED     = 4'd2,
        ST_COUNT_DOWN = 4'd3,
        ST_FREED      = 4'd4,
        ST_HANDED     = 4'd5,
        ST_NOT_HOLDER = 4'd6,
        ST_ALREADY    = 4'd7,
        ST_OVERFLOW   = 4'd8
    } status_t;

    typedef struct packed {
        logic            func;
        logic [ID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    woken_thread;
        logic               holder_present;
        logic [ID_W-1:0]    holder_now;
        logic [DEPTH_W-1:0] depth_now;
    } rsp_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic cmp;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rlfw_cell.sv -----
// one waiter slot of the queue chain
`timescale 1ns / 1ps
`default_nettype none

module rlfw_cell #(
    parameter int TID_W = 8
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  rlfw_pkg::cell_ctrl_t    ctrl,
    input  wire  [TID_W-1:0]        key,
    input  wire                     prev_valid,
    input  wire                     next_valid,
    input  wire  [TID_W-1:0]        next_id,
    output logic                    valid,
    output logic [TID_W-1:0]        id,
    output logic                    match
);

    logic             valid_reg, valid_next;
    logic [TID_W-1:0] id_reg, id_next;
    logic             match_reg, match_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        match_next = match_reg;
        if (ctrl.pop)
        begin
            valid_next = next_valid;
            id_next    = next_id;
        end
        else if (ctrl.push && prev_valid && !valid_reg)
        begin
            valid_next = 1'b1;
            id_next    = key;
        end
        if (ctrl.cmp)
        begin
            match_next = valid_reg && (id_reg == key);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/recursive_lock_with_fifo_waiters_core.sv -----
// recursive lock with a first-in first-out queue of waiting threads
`timescale 1ns / 1ps
`default_nettype none

// Each request word (acquire or release, with a thread id) is first accepted into the input
// register. Next, every slot of the waiter chain compares its id against the requester.
// Then the block decides and updates holder, count and queue, and the response is loaded
// into an output register at the end of that deciding cycle. The deciding cycle is held for
// as long as an earlier response still waits unaccepted in that register. The next request
// is taken only in the cycle after the decision.
// Waiters live in a chain of MAX_WAITERS slots with the oldest at the front;
// a handover shifts the whole chain forward by one slot.
module recursive_lock_with_fifo_waiters_core #(
    parameter int MAX_WAITERS = 16,
    parameter int ID_BITS     = 8,
    parameter int COUNT_MAX   = 255
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              req_valid,
    output logic             req_ready,
    input  rlfw_pkg::req_t   req,
    output logic             rsp_valid,
    input  wire              rsp_ready,
    output rlfw_pkg::rsp_t   rsp
);

    localparam int TID_W = (ID_BITS < rlfw_pkg::ID_W) ? ID_BITS : rlfw_pkg::ID_W;
    localparam int CNT_W = $clog2(COUNT_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    rlfw_pkg::req_t      req_reg;
    logic                held_reg, held_next;
    logic [TID_W-1:0]    holder_reg, holder_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rlfw_pkg::rsp_t      rsp_reg, rsp_next;

    rlfw_pkg::cell_ctrl_t ctrl;
    logic                 push, pop, fire;
    logic [TID_W-1:0]     key;
    logic [TID_W-1:0]     woken;
    rlfw_pkg::status_t    status;

    logic [MAX_WAITERS-1:0] cell_valid;
    logic [MAX_WAITERS-1:0] cell_match;
    logic [TID_W-1:0]       cell_id [MAX_WAITERS];

    logic                   dup, full, empty;
    logic [TID_W+7:0]       woken_ext, holder_ext;
    logic [CNT_W+7:0]       cnt_ext;

    assign key   = req_reg.thread_id[TID_W-1:0];
    assign dup   = |cell_match;
    assign full  = cell_valid[MAX_WAITERS-1];
    assign empty = !cell_valid[0];
    assign fire  = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);

    assign ctrl.push = push && fire;
    assign ctrl.pop  = pop && fire;
    assign ctrl.cmp  = (state_reg == S_MATCH);

    // waiter chain, front slot holds the oldest waiter
    for (genvar i = 0; i < MAX_WAITERS; i++)
    begin : g_cell
        logic             prev_v;
        logic             next_v;
        logic [TID_W-1:0] next_i;

        if (i == 0)
        begin : g_first
            assign prev_v = 1'b1;
        end
        else
        begin : g_mid
            assign prev_v = cell_valid[i-1];
        end

        if (i == MAX_WAITERS - 1)
        begin : g_last
            assign next_v = 1'b0;
            assign next_i = '0;
        end
        else
        begin : g_inner
            assign next_v = cell_valid[i+1];
            assign next_i = cell_id[i+1];
        end

        rlfw_cell #(
            .TID_W (TID_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key),
            .prev_valid (prev_v),
            .next_valid (next_v),
            .next_id    (next_i),
            .valid      (cell_valid[i]),
            .id         (cell_id[i]),
            .match      (cell_match[i])
        );
    end

    // lock decision
    always_comb
    begin
        held_next   = held_reg;
        holder_next = holder_reg;
        cnt_next    = cnt_reg;
        push        = 1'b0;
        pop         = 1'b0;
        woken       = '0;
        if (req_reg.func == rlfw_pkg::FUNC_ACQUIRE)
        begin
            if (held_reg && holder_reg == key)
            begin
                if (cnt_reg >= CNT_W'(COUNT_MAX))
                begin
                    status = rlfw_pkg::ST_OVERFLOW;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                    status   = rlfw_pkg::ST_REGRANTED;
                end
            end
            else if (!held_reg)
            begin
                held_next   = 1'b1;
                holder_next = key;
                cnt_next    = CNT_W'(1);
                status      = rlfw_pkg::ST_GRANTED;
            end
            else if (dup)
            begin
                status = rlfw_pkg::ST_ALREADY;
            end
            else if (full)
            begin
                status = rlfw_pkg::ST_OVERFLOW;
            end
            else
            begin
                push   = 1'b1;
                status = rlfw_pkg::ST_QUEUED;
            end
        end
        else
        begin
            if (!held_reg || holder_reg != key)
            begin
                status = rlfw_pkg::ST_NOT_HOLDER;
            end
            else if (cnt_reg > CNT_W'(1))
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                status   = rlfw_pkg::ST_COUNT_DOWN;
            end
            else if (!empty)
            begin
                woken       = cell_id[0];
                pop         = 1'b1;
                holder_next = cell_id[0];
                cnt_next    = CNT_W'(1);
                status      = rlfw_pkg::ST_HANDED;
            end
            else
            begin
                held_next   = 1'b0;
                holder_next = '0;
                cnt_next    = '0;
                status      = rlfw_pkg::ST_FREED;
            end
        end
    end

    assign woken_ext  = {8'd0, woken};
    assign holder_ext = {8'd0, holder_next};
    assign cnt_ext    = {8'd0, cnt_next};

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_valid_next          = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (fire)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.status         = status;
            rsp_next.woken_thread   = woken_ext[7:0];
            rsp_next.holder_present = held_next;
            rsp_next.holder_now     = holder_ext[7:0];
            rsp_next.depth_now      = cnt_ext[7:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_MATCH;
                end
            end
            S_MATCH:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= 1'b0;
            holder_reg    <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (fire)
            begin
                held_reg   <= held_next;
                holder_reg <= holder_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
